>>> src/tsp_pkg.sv
// Shared constants, register codes and divider handshake types for the
// tone sequence player. No dependencies.
package tsp_pkg;

	localparam int unsigned TABLE_DEPTH    = 256;
	localparam int unsigned CLOCK_HZ       = 1000000;
	localparam int unsigned REPEAT_REST_MS = 5000;

	localparam int unsigned IDX_W   = 8;
	localparam int unsigned FREQ_W  = 16;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned POS_W   = 9;
	localparam int unsigned CNT_W   = 9;
	localparam int unsigned GAP_W   = 16;
	localparam int unsigned ENTRY_W = FREQ_W + TIME_W;

	localparam int unsigned RAM_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int unsigned DIV_NUM_W = $clog2(CLOCK_HZ + 1);
	localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

	localparam logic [FREQ_W-1:0] TONE_MAX = 16'hffff;

	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 48;

	typedef enum logic [1:0] {
		REG_NOTE_COUNT    = 2'd0,
		REG_REPEAT_ENABLE = 2'd1,
		REG_GAP_MS        = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic              start;
		logic [FREQ_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [FREQ_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> src/tsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tsp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/tsp_div.sv
// Restoring divider: CLOCK_HZ over a 16-bit divisor, one quotient bit per cycle,
// quotient saturated to 16 bits. Depends on tsp_pkg.
module tsp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tsp_pkg::div_req_t req,
	output tsp_pkg::div_rsp_t rsp
);
	import tsp_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FREQ_W:0]      rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [FREQ_W-1:0]    div_q;

	logic [FREQ_W:0] shifted;
	logic            fits;
	logic [31:0]     quo_wide;

	// One restoring step: bring in the next dividend bit, subtract if it fits.
	assign shifted = {rem_q[FREQ_W-1:0], quo_q[DIV_NUM_W-1]};
	assign fits    = shifted >= {1'b0, div_q};

	assign quo_wide     = 32'(quo_q);
	assign rsp.done     = done_q;
	assign rsp.quotient = (quo_wide > 32'(TONE_MAX)) ? TONE_MAX : quo_wide[FREQ_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= DIV_NUM_W'(CLOCK_HZ);
				div_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= fits ? (shifted - {1'b0, div_q}) : shifted;
				quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> src/tone_sequence_player.sv
// Tone sequence player: a load, a countdown tick or an end-of-melody tick goes to the done
// state, which raises m_tvalid once the output register is free; a tick that starts a rest
// note passes through the read state first. A tick that starts a tone takes one table read
// and DIV_NUM_W divider steps (20 at 1 MHz). One beat is in work at a time; the next is
// taken once the result sits in the output register, which may still wait for m_tready. Reset
// clears playback state, registers and the output register; the note table is not cleared.
module tone_sequence_player (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tsp_pkg::IN_DATA_W-1:0]       s_tdata,  // entry_index, entry_freq, entry_time
	input  logic [0:0]                          s_tuser,  // kind
	// Result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tsp_pkg::OUT_DATA_W-1:0]      m_tdata,  // tone_period, duty_compare,
	                                                      // position, finished, zero pad
	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tsp_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [tsp_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [tsp_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);
	import tsp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [CNT_W-1:0] note_count_q;
	logic             repeat_q;
	logic [GAP_W-1:0] gap_q;

	// Playback state
	logic [TIME_W-1:0] time_left_q;
	logic [POS_W-1:0]  next_index_q;
	logic [FREQ_W-1:0] period_q;
	logic [FREQ_W-1:0] duty_q;
	logic              done_q;

	// Output register
	logic              m_tvalid_q;
	logic [FREQ_W-1:0] out_period_q;
	logic [FREQ_W-1:0] out_duty_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_fin_q;

	// Beat fields
	logic              in_kind;
	logic [IDX_W-1:0]  in_index;
	logic [FREQ_W-1:0] in_freq;
	logic [TIME_W-1:0] in_time;

	logic              s_accept;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;
	logic              end_of_table;
	logic              out_free;

	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [RAM_AW-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign in_kind  = s_tuser[0];
	assign in_index = s_tdata[IDX_W-1:0];
	assign in_freq  = s_tdata[IDX_W +: FREQ_W];
	assign in_time  = s_tdata[IDX_W+FREQ_W +: TIME_W];

	// Take a beat only with nothing in flight; the output register may still be full.
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - 2*FREQ_W - POS_W - 1){1'b0}},
	                   out_fin_q, out_pos_q, out_duty_q, out_period_q};
	assign out_free = !m_tvalid_q || m_tready;

	// Configuration port: always ready, word address in paddr[3:2].
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_NOTE_COUNT:    prdata = APB_DATA_W'(note_count_q);
			REG_REPEAT_ENABLE: prdata = APB_DATA_W'(repeat_q);
			REG_GAP_MS:        prdata = APB_DATA_W'(gap_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_count_q <= '0;
			repeat_q     <= 1'b0;
			gap_q        <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_NOTE_COUNT:    note_count_q <= pwdata[CNT_W-1:0];
				REG_REPEAT_ENABLE: repeat_q     <= pwdata[0];
				REG_GAP_MS:        gap_q        <= pwdata[GAP_W-1:0];
				default:           ;
			endcase
		end
	end

	// The melody ends once the position reaches the note count, capped at the table size.
	assign end_of_table = (32'(next_index_q) >= 32'(note_count_q)) ||
	                      (32'(next_index_q) >= TABLE_DEPTH);

	// Note table: frequency in the low half, duration in the high half.
	// Out-of-table loads are dropped; every accepted beat reads the current position.
	assign ram_we    = s_accept && in_kind && (32'(in_index) < TABLE_DEPTH);
	assign ram_waddr = RAM_AW'(in_index);
	assign ram_raddr = RAM_AW'(next_index_q);

	tsp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({in_time, in_freq}),
		.re    (s_accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Start the divider on the fetched frequency when it is not a rest.
	assign div_req.start   = (state_q == ST_READ) && (ram_rdata[FREQ_W-1:0] != '0);
	assign div_req.divisor = ram_rdata[FREQ_W-1:0];

	tsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			time_left_q  <= '0;
			next_index_q <= '0;
			period_q     <= '0;
			duty_q       <= '0;
			done_q       <= 1'b0;
			m_tvalid_q   <= 1'b0;
			out_period_q <= '0;
			out_duty_q   <= '0;
			out_pos_q    <= '0;
			out_fin_q    <= 1'b0;
		end else begin
			// Drop the held result once the sink takes it.
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_DONE;
						if (!in_kind) begin
							if (time_left_q != '0) begin
								// Count down; silence the tail of the note.
								if (time_left_q <= gap_q) begin
									duty_q <= period_q;
								end
								time_left_q <= time_left_q - 1'b1;
							end else if (end_of_table) begin
								period_q <= TONE_MAX;
								duty_q   <= '0;
								if (repeat_q) begin
									time_left_q  <= TIME_W'(REPEAT_REST_MS);
									next_index_q <= '0;
									done_q       <= 1'b0;
								end else begin
									done_q <= 1'b1;
								end
							end else begin
								// Next note: wait for the table read.
								state_q <= ST_READ;
							end
						end
					end
				end
				ST_READ: begin
					time_left_q  <= ram_rdata[FREQ_W +: TIME_W];
					next_index_q <= next_index_q + 1'b1;
					done_q       <= 1'b0;
					if (ram_rdata[FREQ_W-1:0] == '0) begin
						period_q <= TONE_MAX;
						duty_q   <= '0;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						period_q <= div_rsp.quotient;
						duty_q   <= div_rsp.quotient >> 1;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold the result until the output register is free.
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_period_q <= period_q;
						out_duty_q   <= duty_q;
						out_pos_q    <= next_index_q;
						out_fin_q    <= done_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");

	a_finished_silent: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (period_q == TONE_MAX && duty_q == '0 && time_left_q == '0))
		else $error("finished melody is not silent");

	a_position_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(next_index_q) <= TABLE_DEPTH)
		else $error("position ran past the note table");

	a_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> state_q != ST_IDLE)
		else $error("sequencer idle right after taking a beat");
`endif

endmodule
